// ----- sv/assert_macros.svh -----
// Assertion shorthands, clocked on i_clk with synchronous active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CSAB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: check failed");

// Checked on every edge, reset included.
`define CSAB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("%m: check failed");

`endif

// ----- sv/csab_pkg.sv -----
package csab_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int CFG_DW    = 13;                    // dimension register width
    localparam int POS_W     = 14;                    // signed position width
    localparam int DIM_W     = $clog2(MAX_DIM + 1);   // clamped dimension width
    localparam int CNT_W     = 13;                    // row / column counter width
    localparam int CRD_W     = 14;                    // offset + counter sums
    localparam int GEO_W     = 16;                    // signed clip arithmetic
    localparam int IDX_W     = 24;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 16;                    // a*s + (255-a)*b
    localparam int REG_IDX_W = 3;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCREEN_W = 3'd0,
        REG_SCREEN_H = 3'd1,
        REG_SPRITE_W = 3'd2,
        REG_SPRITE_H = 3'd3,
        REG_POS_X    = 3'd4,
        REG_POS_Y    = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        WM_NONE = 2'd0,
        WM_RGB  = 2'd1,
        WM_ALL  = 2'd2
    } t_wmode;

    typedef struct packed {
        logic [CFG_DW-1:0]       screen_w;
        logic [CFG_DW-1:0]       screen_h;
        logic [CFG_DW-1:0]       sprite_w;
        logic [CFG_DW-1:0]       sprite_h;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_cfg;

    // Coordinates of one pixel pair, zero when the clipped area is empty.
    typedef struct packed {
        logic             empty;
        logic             last;
        logic [CRD_W-1:0] xs;   // screen column
        logic [CRD_W-1:0] ys;   // screen row
        logic [CRD_W-1:0] tx;   // sprite column
        logic [CRD_W-1:0] ty;   // sprite row
        logic [DIM_W-1:0] sw;   // screen stride
        logic [DIM_W-1:0] tw;   // sprite stride
    } t_coord;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DW-1:0] v);
        logic [DIM_W-1:0] r;
        if (int'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // floor(x/255), exact for x below 65535
    function automatic logic [PIX_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + (SUM_W+1)'(1) + (SUM_W+1)'(x >> 8);
        return PIX_W'(t >> 8);
    endfunction

endpackage

// ----- sv/clipped_sprite_alpha_blit.sv -----
// Channel   Direction  Handshake                  Payload
// ------    ---------  -------------------------  ----------------------------------
// pixel in  in         i_valid / o_stall          i_sprite_{red,green,blue,alpha},
//                                                 i_back_{red,green,blue}
// result    out        o_valid / i_stall          o_screen_index, o_sprite_index,
//                                                 o_out_{red,green,blue,alpha},
//                                                 o_write_mode, o_last_pixel
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request per clock while i_stall is low; three register stages from accept to result.
// Stage 1 holds the pixel pair and its clipped coordinates, stage 2 the stride
// multiplies and blend products, stage 3 the indices and /255 result.
// Each stage refills as soon as its contents move on, so a stalled result only
// backs up the pipe one stage at a time; o_stall rises once all three are full.
// Reset is synchronous: counters and stage valids clear, config registers take their defaults.
// Config writes are always ready and take effect for the next accepted request.
module clipped_sprite_alpha_blit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel pair in
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [csab_pkg::PIX_W-1:0]          i_sprite_red,
    input  logic [csab_pkg::PIX_W-1:0]          i_sprite_green,
    input  logic [csab_pkg::PIX_W-1:0]          i_sprite_blue,
    input  logic [csab_pkg::PIX_W-1:0]          i_sprite_alpha,
    input  logic [csab_pkg::PIX_W-1:0]          i_back_red,
    input  logic [csab_pkg::PIX_W-1:0]          i_back_green,
    input  logic [csab_pkg::PIX_W-1:0]          i_back_blue,
    // result out
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [csab_pkg::IDX_W-1:0]          o_screen_index,
    output logic [csab_pkg::IDX_W-1:0]          o_sprite_index,
    output logic [csab_pkg::PIX_W-1:0]          o_out_red,
    output logic [csab_pkg::PIX_W-1:0]          o_out_green,
    output logic [csab_pkg::PIX_W-1:0]          o_out_blue,
    output logic [csab_pkg::PIX_W-1:0]          o_out_alpha,
    output logic [1:0]                          o_write_mode,
    output logic                                o_last_pixel,
    // config write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [csab_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [csab_pkg::POS_W-1:0]          i_cfg_data
);

    csab_pkg::t_cfg   cfg;
    csab_pkg::t_coord crd;

    logic free1, free2, free3, accept;
    logic r_v1, r_v2, r_v3;

    // stage 1
    csab_pkg::t_coord           r1_crd;
    logic [csab_pkg::PIX_W-1:0] r1_sr, r1_sg, r1_sb, r1_sa, r1_br, r1_bg, r1_bb;
    csab_pkg::t_wmode           mode1;

    // stage 2
    logic [csab_pkg::IDX_W-1:0] r2_si_prod, r2_ti_prod;
    logic [csab_pkg::CRD_W-1:0] r2_xs, r2_tx;
    logic [csab_pkg::PIX_W-1:0] r2_alpha;
    csab_pkg::t_wmode           r2_mode;
    logic                       r2_last;

    // stage 3
    logic [csab_pkg::IDX_W-1:0] r3_si, r3_ti;
    logic [csab_pkg::PIX_W-1:0] r3_alpha;
    csab_pkg::t_wmode           r3_mode;
    logic                       r3_last;

    // A stage may load when it is empty or its contents move on this edge.
    assign free3  = !r_v3 || !i_stall;
    assign free2  = !r_v2 || free3;
    assign free1  = !r_v1 || free2;
    assign accept = i_valid && free1;
    assign o_stall = !free1;
    assign o_cfg_ready = 1'b1;

    csab_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // row/column counters and clip geometry; counters step on each accept
    csab_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (accept),
        .o_crd   (crd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: capture request and its coordinates
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r1_crd <= crd;
            r1_sr  <= i_sprite_red;
            r1_sg  <= i_sprite_green;
            r1_sb  <= i_sprite_blue;
            r1_sa  <= i_sprite_alpha;
            r1_br  <= i_back_red;
            r1_bg  <= i_back_green;
            r1_bb  <= i_back_blue;
        end
    end

    // Empty clip area and transparent pixels write nothing; opaque copies.
    always_comb begin
        priority if (r1_crd.empty || r1_sa == '0) begin
            mode1 = csab_pkg::WM_NONE;
        end else if (r1_sa == csab_pkg::ALPHA_OPAQUE) begin
            mode1 = csab_pkg::WM_ALL;
        end else begin
            mode1 = csab_pkg::WM_RGB;
        end
    end

    // stage 2: row * stride products, mod 2^24
    always_ff @(posedge i_clk) begin
        if (free2) begin
            r2_si_prod <= csab_pkg::IDX_W'(r1_crd.ys) * csab_pkg::IDX_W'(r1_crd.sw);
            r2_ti_prod <= csab_pkg::IDX_W'(r1_crd.ty) * csab_pkg::IDX_W'(r1_crd.tw);
            r2_xs      <= r1_crd.xs;
            r2_tx      <= r1_crd.tx;
            r2_alpha   <= r1_sa;
            r2_mode    <= mode1;
            r2_last    <= r1_crd.last;
        end
    end

    // stage 3: add column, finalize
    always_ff @(posedge i_clk) begin
        if (free3) begin
            r3_si    <= r2_si_prod + csab_pkg::IDX_W'(r2_xs);
            r3_ti    <= r2_ti_prod + csab_pkg::IDX_W'(r2_tx);
            r3_alpha <= (r2_mode == csab_pkg::WM_ALL) ? r2_alpha : '0;
            r3_mode  <= r2_mode;
            r3_last  <= r2_last;
        end
    end

    // per-channel blend, stages 2 and 3
    csab_blend u_blend_r (
        .i_clk    (i_clk),
        .i_en2    (free2),
        .i_en3    (free3),
        .i_sprite (r1_sr),
        .i_back   (r1_br),
        .i_alpha  (r1_sa),
        .i_mode   (mode1),
        .o_pix    (o_out_red)
    );

    csab_blend u_blend_g (
        .i_clk    (i_clk),
        .i_en2    (free2),
        .i_en3    (free3),
        .i_sprite (r1_sg),
        .i_back   (r1_bg),
        .i_alpha  (r1_sa),
        .i_mode   (mode1),
        .o_pix    (o_out_green)
    );

    csab_blend u_blend_b (
        .i_clk    (i_clk),
        .i_en2    (free2),
        .i_en3    (free3),
        .i_sprite (r1_sb),
        .i_back   (r1_bb),
        .i_alpha  (r1_sa),
        .i_mode   (mode1),
        .o_pix    (o_out_blue)
    );

    assign o_valid        = r_v3;
    assign o_screen_index = r3_si;
    assign o_sprite_index = r3_ti;
    assign o_out_alpha    = r3_alpha;
    assign o_write_mode   = r3_mode;
    assign o_last_pixel   = r3_last;

endmodule

// ----- sv/csab_cfg.sv -----
module csab_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [csab_pkg::REG_IDX_W-1:0]     i_index,
    input  logic [csab_pkg::POS_W-1:0]         i_data,
    output csab_pkg::t_cfg                     o_cfg
);

    csab_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_w <= csab_pkg::CFG_DW'(640);
            r_cfg.screen_h <= csab_pkg::CFG_DW'(480);
            r_cfg.sprite_w <= csab_pkg::CFG_DW'(64);
            r_cfg.sprite_h <= csab_pkg::CFG_DW'(64);
            r_cfg.pos_x    <= '0;
            r_cfg.pos_y    <= '0;
        end else if (i_we) begin
            unique case (csab_pkg::t_reg_idx'(i_index))
                csab_pkg::REG_SCREEN_W: r_cfg.screen_w <= i_data[csab_pkg::CFG_DW-1:0];
                csab_pkg::REG_SCREEN_H: r_cfg.screen_h <= i_data[csab_pkg::CFG_DW-1:0];
                csab_pkg::REG_SPRITE_W: r_cfg.sprite_w <= i_data[csab_pkg::CFG_DW-1:0];
                csab_pkg::REG_SPRITE_H: r_cfg.sprite_h <= i_data[csab_pkg::CFG_DW-1:0];
                csab_pkg::REG_POS_X:    r_cfg.pos_x    <= $signed(i_data);
                csab_pkg::REG_POS_Y:    r_cfg.pos_y    <= $signed(i_data);
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/csab_scan.sv -----
module csab_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csab_pkg::t_cfg  i_cfg,
    input  logic            i_adv,
    output csab_pkg::t_coord o_crd
);

    logic [csab_pkg::CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [csab_pkg::DIM_W-1:0] sw, sh, tw, th;
    logic signed [csab_pkg::GEO_W-1:0] px, py, x0, y0, x1s, y1s, x1, y1, cw, ch;
    logic signed [csab_pkg::GEO_W-1:0] colp, rowp;
    logic [csab_pkg::CRD_W-1:0] left, top;
    logic empty, wrap_col, wrap_row;

    always_comb begin
        sw = csab_pkg::clamp_dim(i_cfg.screen_w);
        sh = csab_pkg::clamp_dim(i_cfg.screen_h);
        tw = csab_pkg::clamp_dim(i_cfg.sprite_w);
        th = csab_pkg::clamp_dim(i_cfg.sprite_h);
        px = csab_pkg::GEO_W'(i_cfg.pos_x);
        py = csab_pkg::GEO_W'(i_cfg.pos_y);

        // clip rectangle [x0,x1) x [y0,y1)
        x0  = (px < 0) ? '0 : px;
        y0  = (py < 0) ? '0 : py;
        x1s = px + csab_pkg::GEO_W'(tw);
        y1s = py + csab_pkg::GEO_W'(th);
        // far edge may sit left of or above the screen, so compare signed
        x1  = (x1s < $signed(csab_pkg::GEO_W'(sw))) ? x1s : csab_pkg::GEO_W'(sw);
        y1  = (y1s < $signed(csab_pkg::GEO_W'(sh))) ? y1s : csab_pkg::GEO_W'(sh);
        cw  = x1 - x0;
        ch  = y1 - y0;
        empty = (cw <= 0) || (ch <= 0);

        left = csab_pkg::CRD_W'(x0 - px);
        top  = csab_pkg::CRD_W'(y0 - py);

        colp = csab_pkg::GEO_W'(r_col) + csab_pkg::GEO_W'(1);
        rowp = csab_pkg::GEO_W'(r_row) + csab_pkg::GEO_W'(1);
        wrap_col = colp >= cw;
        wrap_row = rowp >= ch;

        if (empty) begin
            o_crd = '0;
            o_crd.empty = 1'b1;
            o_crd.last  = 1'b1;
        end else begin
            o_crd.empty = 1'b0;
            o_crd.last  = wrap_col && wrap_row;
            o_crd.xs = csab_pkg::CRD_W'(x0) + csab_pkg::CRD_W'(r_col);
            o_crd.ys = csab_pkg::CRD_W'(y0) + csab_pkg::CRD_W'(r_row);
            o_crd.tx = left + csab_pkg::CRD_W'(r_col);
            o_crd.ty = top + csab_pkg::CRD_W'(r_row);
            o_crd.sw = sw;
            o_crd.tw = tw;
        end

        n_col = r_col;
        n_row = r_row;
        if (empty) begin
            n_col = '0;
            n_row = '0;
        end else if (wrap_col) begin
            n_col = '0;
            n_row = wrap_row ? '0 : csab_pkg::CNT_W'(r_row + 1'b1);
        end else begin
            n_col = csab_pkg::CNT_W'(r_col + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- sv/csab_blend.sv -----
module csab_blend (
    input  logic                        i_clk,
    input  logic                        i_en2,
    input  logic                        i_en3,
    input  logic [csab_pkg::PIX_W-1:0]  i_sprite,
    input  logic [csab_pkg::PIX_W-1:0]  i_back,
    input  logic [csab_pkg::PIX_W-1:0]  i_alpha,
    input  csab_pkg::t_wmode            i_mode,
    output logic [csab_pkg::PIX_W-1:0]  o_pix
);

    logic [csab_pkg::SUM_W-1:0] r_sum;
    logic [csab_pkg::PIX_W-1:0] r_sprite, r_pix;
    csab_pkg::t_wmode           r_mode;
    logic [csab_pkg::PIX_W-1:0] inv_a;

    assign inv_a = csab_pkg::ALPHA_OPAQUE - i_alpha;

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_sum    <= csab_pkg::SUM_W'(i_alpha) * csab_pkg::SUM_W'(i_sprite)
                      + csab_pkg::SUM_W'(inv_a) * csab_pkg::SUM_W'(i_back);
            r_sprite <= i_sprite;
            r_mode   <= i_mode;
        end
        if (i_en3) begin
            unique case (r_mode)
                csab_pkg::WM_ALL: r_pix <= r_sprite;
                csab_pkg::WM_RGB: r_pix <= csab_pkg::div255(r_sum);
                default:          r_pix <= '0;
            endcase
        end
    end

    assign o_pix = r_pix;

endmodule

// ----- sv/csab_check.sv -----
`include "assert_macros.svh"

module csab_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_stall,
    input  logic                                o_valid,
    input  logic [csab_pkg::PIX_W-1:0]          o_out_red,
    input  logic [csab_pkg::PIX_W-1:0]          o_out_green,
    input  logic [csab_pkg::PIX_W-1:0]          o_out_blue,
    input  logic [csab_pkg::PIX_W-1:0]          o_out_alpha,
    input  logic [1:0]                          o_write_mode
);

    // a stalled result stays offered
    `CSAB_ASSERT(a_hold_valid, o_valid && i_stall |=> o_valid)

    // no-write results carry zero bytes
    `CSAB_ASSERT(a_none_zero, o_valid && o_write_mode == csab_pkg::WM_NONE |-> o_out_red == '0 && o_out_green == '0 && o_out_blue == '0 && o_out_alpha == '0)

    // alpha byte only goes out with a full four-byte write
    `CSAB_ASSERT(a_alpha_full, o_valid && o_write_mode != csab_pkg::WM_ALL |-> o_out_alpha == '0)

    // pipe is empty after reset
    `CSAB_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid)

endmodule

bind clipped_sprite_alpha_blit csab_check u_check (.*);
